// ===== sv/bm25_pkg.sv =====
// Package: codes, word types and single-precision arithmetic helpers for the BM25 scorer.
`timescale 1ns / 1ps
package bm25_pkg;

  localparam logic [31:0] QNanBits = 32'h7FC0_0000;
  localparam logic [31:0] OneBits  = 32'h3F80_0000;

  localparam logic [1:0] VarBm1    = 2'd0;
  localparam logic [1:0] VarBm15   = 2'd1;
  localparam logic [1:0] MergeSum  = 2'd1;
  localparam logic [1:0] MergeMax  = 2'd2;

  localparam int unsigned AddrW = 5;
  localparam logic [2:0] RegVariant    = 3'd0;
  localparam logic [2:0] RegMergeMode  = 3'd1;
  localparam logic [2:0] RegUseFb      = 3'd2;
  localparam logic [2:0] RegBoostedIdf = 3'd3;
  localparam logic [2:0] RegNormConst  = 3'd4;
  localparam logic [2:0] RegNormLength = 3'd5;

  localparam logic [1:0]  VariantRst   = 2'd2;
  localparam logic [1:0]  MergeRst     = 2'd0;
  localparam logic [31:0] NormConstRst = 32'h3F99_999A;

  typedef struct packed {
    logic [31:0] term_freq;
    logic [31:0] doc_length;
    logic [31:0] doc_boost;
    logic [31:0] prior_score;
  } in_word_t;

  typedef struct packed {
    logic [31:0] score;
  } out_word_t;

  function automatic logic f_is_nan(input logic [31:0] a);
    return (&a[30:23]) & (|a[22:0]);
  endfunction

  function automatic logic f_is_inf(input logic [31:0] a);
    return (&a[30:23]) & ~(|a[22:0]);
  endfunction

  function automatic logic f_is_zero(input logic [31:0] a);
    return ~(|a[30:0]);
  endfunction

  // effective biased exponent, subnormals count as 1
  function automatic logic signed [12:0] f_exp(input logic [31:0] a);
    return (a[30:23] == 8'd0) ? 13'sd1 : $signed({5'd0, a[30:23]});
  endfunction

  function automatic logic [23:0] f_man(input logic [31:0] a);
    return {|a[30:23], a[22:0]};
  endfunction

  // value = m * 2^(e - 175); normalize, round to nearest even, pack
  function automatic logic [31:0] fp_pack(input logic s, input logic signed [12:0] e,
                                          input logic [49:0] m);
    logic [5:0] lz;
    logic [49:0] mn;
    logic [49:0] mask;
    logic signed [12:0] en;
    logic signed [12:0] sh_full;
    logic [5:0] sh;
    logic st;
    logic inc;
    logic [7:0] ef;
    logic [30:0] mag;
    logic [31:0] res;
    lz = '0;
    for (int i = 0; i < 50; i++) begin
      if (m[i]) lz = 6'(49 - i);
    end
    mn = m << lz;
    en = e + 13'sd1 - $signed({7'd0, lz});
    ef = en[7:0];
    if (en <= 13'sd0) begin
      sh_full = 13'sd1 - en;
      sh = (sh_full > 13'sd50) ? 6'd50 : sh_full[5:0];
      mask = (50'd1 << sh) - 50'd1;
      st = |(mn & mask);
      mn = (mn >> sh) | {49'd0, st};
      ef = 8'd0;
    end
    inc = mn[25] & ((|mn[24:0]) | mn[26]);
    mag = {ef, mn[48:26]} + {30'd0, inc};
    if (m == '0) begin
      res = {s, 31'd0};
    end else if (en >= 13'sd255) begin
      res = {s, 8'hFF, 23'd0};
    end else begin
      res = {s, mag};
    end
    return res;
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic s;
    logic [47:0] prod;
    logic signed [12:0] e;
    logic [31:0] res;
    s = a[31] ^ b[31];
    prod = 48'(f_man(a)) * 48'(f_man(b));
    e = f_exp(a) + f_exp(b) - 13'sd125;
    if (f_is_nan(a) | f_is_nan(b) | (f_is_inf(a) & f_is_zero(b))
        | (f_is_zero(a) & f_is_inf(b))) begin
      res = QNanBits;
    end else if (f_is_inf(a) | f_is_inf(b)) begin
      res = {s, 8'hFF, 23'd0};
    end else if (f_is_zero(a) | f_is_zero(b)) begin
      res = {s, 31'd0};
    end else begin
      res = fp_pack(s, e, {2'd0, prod});
    end
    return res;
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] big;
    logic [31:0] sml;
    logic signed [12:0] eb;
    logic signed [12:0] es;
    logic [49:0] mbg;
    logic [49:0] msm;
    logic [49:0] mask;
    logic [49:0] sum;
    logic [7:0] d;
    logic [5:0] sh;
    logic st;
    logic [31:0] res;
    if (a[30:0] >= b[30:0]) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    eb = f_exp(big);
    es = f_exp(sml);
    d = eb[7:0] - es[7:0];
    sh = (d > 8'd50) ? 6'd50 : d[5:0];
    mbg = {1'b0, f_man(big), 25'd0};
    msm = {1'b0, f_man(sml), 25'd0};
    mask = (50'd1 << sh) - 50'd1;
    st = |(msm & mask);
    msm = (msm >> sh) | {49'd0, st};
    sum = (a[31] == b[31]) ? (mbg + msm) : (mbg - msm);
    if (f_is_nan(a) | f_is_nan(b) | (f_is_inf(a) & f_is_inf(b) & (a[31] != b[31]))) begin
      res = QNanBits;
    end else if (f_is_inf(a)) begin
      res = a;
    end else if (f_is_inf(b)) begin
      res = b;
    end else if (f_is_zero(a) & f_is_zero(b)) begin
      res = {a[31] & b[31], 31'd0};
    end else if (f_is_zero(a)) begin
      res = b;
    end else if (f_is_zero(b)) begin
      res = a;
    end else if (sum == '0) begin
      res = 32'd0;
    end else begin
      res = fp_pack(big[31], eb, sum);
    end
    return res;
  endfunction

  function automatic logic fp_lt(input logic [31:0] a, input logic [31:0] b);
    logic res;
    if (f_is_nan(a) | f_is_nan(b) | (f_is_zero(a) & f_is_zero(b))) begin
      res = 1'b0;
    end else if (a[31] != b[31]) begin
      res = a[31];
    end else if (!a[31]) begin
      res = a[30:0] < b[30:0];
    end else begin
      res = a[30:0] > b[30:0];
    end
    return res;
  endfunction

  function automatic logic [31:0] u2f(input logic [31:0] u);
    return (u == 32'd0) ? 32'd0 : fp_pack(1'b0, 13'sd157, {u, 18'd0});
  endfunction

  function automatic logic [31:0] fp_canon(input logic [31:0] a);
    return f_is_nan(a) ? QNanBits : a;
  endfunction

endpackage

// ===== sv/bm25_in_if.sv =====
// Interface: input channel carrying one posting word.
`timescale 1ns / 1ps
interface bm25_in_if;
  logic              valid;
  logic              ready;
  bm25_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/bm25_out_if.sv =====
// Interface: output channel carrying one score word.
`timescale 1ns / 1ps
interface bm25_out_if;
  logic               valid;
  logic               ready;
  bm25_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/bm25_fdiv.sv =====
// Pipelined single-precision divider: prescale stage, restoring quotient stages, round stage.
`timescale 1ns / 1ps
module bm25_fdiv #(
  parameter int unsigned PayW = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [31:0]     a_i,
  input  logic [31:0]     b_i,
  input  logic [PayW-1:0] pay_i,
  output logic            valid_o,
  output logic [31:0]     q_o,
  output logic [PayW-1:0] pay_o
);
  import bm25_pkg::*;

  localparam int unsigned QBits = 27;
  localparam int unsigned StepsPerStage = 3;
  localparam int unsigned NStages = QBits / StepsPerStage;

  logic                   v_q   [0:NStages];
  logic                   sp_q  [0:NStages];
  logic [31:0]            spv_q [0:NStages];
  logic                   s_q   [0:NStages];
  logic signed [12:0]     e_q   [0:NStages];
  logic [23:0]            mb_q  [0:NStages];
  logic [25:0]            rem_q [0:NStages];
  logic [QBits-1:0]       quo_q [0:NStages];
  logic [PayW-1:0]        pay_q [0:NStages];
  logic [25:0]            rem_d [1:NStages];
  logic [QBits-1:0]       quo_d [1:NStages];

  logic                   sp_d;
  logic [31:0]            spv_d;
  logic                   s_d;
  logic signed [12:0]     e_d;
  logic [23:0]            ma_r;
  logic [23:0]            mb_r;
  logic [23:0]            ma_n;
  logic [23:0]            mb_n;
  logic [4:0]             lza;
  logic [4:0]             lzb;
  logic                   vout_q;
  logic [31:0]            qout_q;
  logic [PayW-1:0]        pout_q;

  always_comb begin
    s_d = a_i[31] ^ b_i[31];
    ma_r = f_man(a_i);
    mb_r = f_man(b_i);
    lza = '0;
    lzb = '0;
    for (int i = 0; i < 24; i++) begin
      if (ma_r[i]) lza = 5'(23 - i);
      if (mb_r[i]) lzb = 5'(23 - i);
    end
    ma_n = ma_r << lza;
    mb_n = mb_r << lzb;
    e_d = (f_exp(a_i) - $signed({8'd0, lza})) - (f_exp(b_i) - $signed({8'd0, lzb}))
          + 13'sd127;
    sp_d = 1'b1;
    if (f_is_nan(a_i) | f_is_nan(b_i) | (f_is_zero(a_i) & f_is_zero(b_i))
        | (f_is_inf(a_i) & f_is_inf(b_i))) begin
      spv_d = QNanBits;
    end else if (f_is_inf(a_i) | f_is_zero(b_i)) begin
      spv_d = {s_d, 8'hFF, 23'd0};
    end else if (f_is_zero(a_i) | f_is_inf(b_i)) begin
      spv_d = {s_d, 31'd0};
    end else begin
      spv_d = '0;
      sp_d = 1'b0;
    end
  end

  always_comb begin
    for (int k = 1; k <= NStages; k++) begin
      rem_d[k] = rem_q[k-1];
      quo_d[k] = quo_q[k-1];
      for (int j = 0; j < StepsPerStage; j++) begin
        if (rem_d[k] >= {2'd0, mb_q[k-1]}) begin
          rem_d[k] = rem_d[k] - {2'd0, mb_q[k-1]};
          quo_d[k] = {quo_d[k][QBits-2:0], 1'b1};
        end else begin
          quo_d[k] = {quo_d[k][QBits-2:0], 1'b0};
        end
        rem_d[k] = {rem_d[k][24:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NStages; k++) v_q[k] <= 1'b0;
      vout_q <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int k = 1; k <= NStages; k++) v_q[k] <= v_q[k-1];
      vout_q <= v_q[NStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sp_q[0]  <= sp_d;
      spv_q[0] <= spv_d;
      s_q[0]   <= s_d;
      e_q[0]   <= e_d;
      mb_q[0]  <= mb_n;
      rem_q[0] <= {2'd0, ma_n};
      quo_q[0] <= '0;
      pay_q[0] <= pay_i;
      for (int k = 1; k <= NStages; k++) begin
        sp_q[k]  <= sp_q[k-1];
        spv_q[k] <= spv_q[k-1];
        s_q[k]   <= s_q[k-1];
        e_q[k]   <= e_q[k-1];
        mb_q[k]  <= mb_q[k-1];
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
        pay_q[k] <= pay_q[k-1];
      end
      qout_q <= sp_q[NStages] ? spv_q[NStages]
              : fp_pack(s_q[NStages], e_q[NStages],
                        {1'b0, quo_q[NStages], 21'd0, |rem_q[NStages]});
      pout_q <= pay_q[NStages];
    end
  end

  assign valid_o = vout_q;
  assign q_o     = qout_q;
  assign pay_o   = pout_q;

endmodule

// ===== sv/bm25_document_scorer_core.sv =====
// Top level: BM25 posting scorer, APB register port and the scoring pipeline.
// Use: each word on in_i carries one posting (term_freq, doc_length, doc_boost,
// prior_score); each word on out_o carries its merged single-precision score, in order.
// Registers sit on the APB port at byte address 4*i: variant, merge_mode,
// use_filter_boost, boosted_idf, constant norm, length norm. Write them only while idle.
// Every variant takes the same path from input acceptance to output valid; one word
// per cycle is accepted and delivered unless out_o stalls. The path holds the two 11-stage
// dividers (three quotient bits per stage), always in series, plus seven arithmetic stages.
// Every stage moves together: when out_o stalls, the whole pipeline holds and
// in_i.ready drops, so nothing is lost or repeated. Bubbles move while not stalled.
// Reset clears all stage valid bits and loads the register defaults (BM25, overwrite,
// no filter boost, constant norm 1.2).
`timescale 1ns / 1ps
module bm25_document_scorer_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bm25_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  bm25_in_if.sink                      in_i,
  bm25_out_if.source                   out_o
);
  import bm25_pkg::*;

  localparam int unsigned PayAW = 64;
  localparam int unsigned PayBW = 96;

  logic [1:0]  variant_q;
  logic [1:0]  merge_q;
  logic        use_fb_q;
  logic [31:0] idf_q;
  logic [31:0] nc_q;
  logic [31:0] nl_q;
  logic [2:0]  reg_idx;
  logic        wr_en;

  logic adv;
  logic bm15;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  logic [31:0] tf1_q, dl1_q, fb1_q, pr1_q;
  logic [31:0] tf2_q, c0_2_q, p2_q, pr2_q;
  logic [31:0] tf3_q, c0_3_q, c1_3_q, pr3_q;
  logic [31:0] tf4_q, c0_4_q, num4_q, den4_q, pr4_q;
  logic [31:0] c0_5_q, qa5_q, d5_q, pr5_q;
  logic [31:0] r6_q, pr6_q;
  logic [31:0] score_q;

  logic             va;
  logic [31:0]      qa;
  logic [PayAW-1:0] pay_a;
  logic             vb;
  logic [31:0]      qb;
  logic [PayBW-1:0] pay_b;
  logic [31:0]      t6;
  logic [31:0]      r6_d;
  logic [31:0]      score_d;

  assign pready  = 1'b1;
  assign reg_idx = paddr[AddrW-1:2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q <= VariantRst;
      merge_q   <= MergeRst;
      use_fb_q  <= 1'b0;
      idf_q     <= '0;
      nc_q      <= NormConstRst;
      nl_q      <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegVariant:    variant_q <= pwdata[1:0];
        RegMergeMode:  merge_q   <= pwdata[1:0];
        RegUseFb:      use_fb_q  <= pwdata[0];
        RegBoostedIdf: idf_q     <= pwdata;
        RegNormConst:  nc_q      <= pwdata;
        RegNormLength: nl_q      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegVariant:    prdata = {30'd0, variant_q};
      RegMergeMode:  prdata = {30'd0, merge_q};
      RegUseFb:      prdata = {31'd0, use_fb_q};
      RegBoostedIdf: prdata = idf_q;
      RegNormConst:  prdata = nc_q;
      RegNormLength: prdata = nl_q;
      default:       prdata = '0;
    endcase
  end

  assign adv        = ~v7_q | out_o.ready;
  assign in_i.ready = adv;
  assign bm15       = (variant_q == VarBm15);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= va;
      v6_q <= vb;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tf1_q  <= u2f(in_i.data.term_freq);
      dl1_q  <= u2f(in_i.data.doc_length);
      fb1_q  <= in_i.data.doc_boost;
      pr1_q  <= in_i.data.prior_score;

      tf2_q  <= tf1_q;
      c0_2_q <= use_fb_q ? fp_mul(fb1_q, idf_q) : idf_q;
      p2_q   <= fp_mul(nl_q, dl1_q);
      pr2_q  <= pr1_q;

      tf3_q  <= tf2_q;
      c0_3_q <= c0_2_q;
      c1_3_q <= fp_add(nc_q, p2_q);
      pr3_q  <= pr2_q;

      tf4_q  <= tf3_q;
      c0_4_q <= c0_3_q;
      num4_q <= fp_mul(c0_3_q, c1_3_q);
      den4_q <= fp_add(c1_3_q, tf3_q);
      pr4_q  <= pr3_q;

      c0_5_q <= pay_a[63:32];
      qa5_q  <= qa;
      d5_q   <= fp_add(OneBits, qa);
      pr5_q  <= pay_a[31:0];

      r6_q   <= r6_d;
      pr6_q  <= pay_b[31:0];

      score_q <= score_d;
    end
  end

  bm25_fdiv #(.PayW(PayAW)) u_div_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v4_q),
    .a_i     (bm15 ? tf4_q : num4_q),
    .b_i     (bm15 ? nc_q : den4_q),
    .pay_i   ({c0_4_q, pr4_q}),
    .valid_o (va),
    .q_o     (qa),
    .pay_o   (pay_a)
  );

  bm25_fdiv #(.PayW(PayBW)) u_div_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v5_q),
    .a_i     (c0_5_q),
    .b_i     (d5_q),
    .pay_i   ({c0_5_q, qa5_q, pr5_q}),
    .valid_o (vb),
    .q_o     (qb),
    .pay_o   (pay_b)
  );

  // r = c0 - t (BM1 takes r = c0); t is the second quotient for BM15, the first otherwise
  always_comb begin
    t6 = bm15 ? qb : pay_b[63:32];
    if (variant_q == VarBm1) begin
      r6_d = pay_b[95:64];
    end else begin
      r6_d = fp_add(pay_b[95:64], {~t6[31], t6[30:0]});
    end
  end

  always_comb begin
    case (merge_q)
      MergeSum: score_d = fp_add(pr6_q, r6_q);
      MergeMax: score_d = fp_lt(pr6_q, r6_q) ? r6_q : pr6_q;
      default:  score_d = r6_q;
    endcase
    score_d = fp_canon(score_d);
  end

  assign out_o.valid      = v7_q;
  assign out_o.data.score = score_q;

  a_nan_canonical: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v7_q && f_is_nan(score_q)) |-> (score_q == QNanBits))
    else $error("non-canonical NaN on score");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ((v1_q == $past(v1_q)) && (v4_q == $past(v4_q)) && (v6_q == $past(v6_q))))
    else $error("pipeline moved during stall");

  a_out_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(v7_q) |-> $past(adv && v6_q))
    else $error("output valid rose without an advancing item");

endmodule
